// File: rtl/core/mc_tri_pkg.sv
`default_nettype none

package mc_tri_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CRD_W       = 10;
    localparam int POS_W       = 34;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_EDGES   = 12;
    localparam int NUM_AXES    = 3;
    localparam int MAX_TRI     = 5;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int UNIT_W      = SAMPLE_W + 8;
    localparam int PROD_W      = SAMPLE_W + DIFF_W;
    localparam int DVD_W       = PROD_W + 9;
    localparam int QUO_W       = UNIT_W;
    localparam int DIV_STEP    = 2;
    localparam int DIV_STAGES  = QUO_W / DIV_STEP;

    typedef enum logic [1:0] {
        CFG_ISO_LEVEL = 2'd0,
        CFG_CELL_SIZE = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [CRD_W-1:0]           cell_x;
        logic [CRD_W-1:0]           cell_y;
        logic [CRD_W-1:0]           cell_z;
        logic signed [SAMPLE_W-1:0] corner0;
        logic signed [SAMPLE_W-1:0] corner1;
        logic signed [SAMPLE_W-1:0] corner2;
        logic signed [SAMPLE_W-1:0] corner3;
        logic signed [SAMPLE_W-1:0] corner4;
        logic signed [SAMPLE_W-1:0] corner5;
        logic signed [SAMPLE_W-1:0] corner6;
        logic signed [SAMPLE_W-1:0] corner7;
    } cell_t;

    typedef struct packed {
        logic [POS_W-1:0] ax;
        logic [POS_W-1:0] ay;
        logic [POS_W-1:0] az;
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by_coord;
        logic [POS_W-1:0] bz;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [POS_W-1:0] cz;
        logic             last_triangle;
    } tri_t;

    // per edge: low corner, high corner, axis along which it runs
    localparam logic [2:0] EDGE_LO [0:NUM_EDGES-1] = '{
        3'd0, 3'd1, 3'd3, 3'd0, 3'd4, 3'd5, 3'd7, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
    localparam logic [2:0] EDGE_HI [0:NUM_EDGES-1] = '{
        3'd1, 3'd2, 3'd2, 3'd3, 3'd5, 3'd6, 3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7};
    localparam logic [1:0] EDGE_AXIS [0:NUM_EDGES-1] = '{
        2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2};
    // corner offsets, bit 0 = x, bit 1 = y, bit 2 = z
    localparam logic [2:0] CORNER_OFF [0:NUM_CORNERS-1] = '{
        3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110};

    // Edge lists right-aligned, first edge in the highest used nibble,
    // topped by a sentinel nibble of 1.
    localparam logic [63:0] TRI_TAB [0:255] = '{
        64'h1, 64'h1083, 64'h1019, 64'h1183981,
        64'h112a, 64'h108312a, 64'h192a029, 64'h12832a8a98,
        64'h13b2, 64'h10b28b0, 64'h119023b, 64'h11b219b98b,
        64'h13a1ba3, 64'h10a108a8ba, 64'h13903b9ba9, 64'h198aa8b,
        64'h1478, 64'h1430734, 64'h1019847, 64'h1419471731,
        64'h112a847, 64'h134730412a, 64'h192a902847, 64'h12a9297273794,
        64'h18473b2, 64'h1b47b24204, 64'h190184723b, 64'h147b94b9b2921,
        64'h13a13ba784, 64'h11ba14b1047b4, 64'h147890b9bab03, 64'h147b4b99ba,
        64'h1954, 64'h1954083, 64'h1054150, 64'h1854835315,
        64'h112a954, 64'h130812a495, 64'h152a542402, 64'h12a5325354348,
        64'h195423b, 64'h10b208b495, 64'h105401523b, 64'h121525828b485,
        64'h1a3ba13954, 64'h14950818a18ba, 64'h154050b5bab03, 64'h154858aa8b,
        64'h1978579, 64'h1930953573, 64'h1078017157, 64'h1153357,
        64'h1978957a12, 64'h1a12950530573, 64'h1802825857a52, 64'h12a5253357,
        64'h17957893b2, 64'h195797292027b, 64'h123b018178157, 64'h1b21b17715,
        64'h1958857a13a3b, 64'h15705097b010aba0, 64'h1ba0b03a50807570, 64'h1ba57b5,
        64'h1a65, 64'h10835a6, 64'h19015a6, 64'h11831985a6,
        64'h1165261, 64'h1165126308, 64'h1965906026, 64'h1598582526328,
        64'h123ba65, 64'h1b08b20a65, 64'h101923b5a6, 64'h15a61929b298b,
        64'h163b653513, 64'h108b0b50515b6, 64'h13b6036065059, 64'h165969bb98,
        64'h15a6478, 64'h143047365a, 64'h11905a6847, 64'h1a65197173794,
        64'h1612651478, 64'h1125526304347, 64'h1847905065026, 64'h1739794329596269,
        64'h13b2784a65, 64'h15a647242027b, 64'h101947823b5a6, 64'h19219b294b7b45a6,
        64'h18473b53515b6, 64'h151b5b610b7b404b, 64'h1059065036b63847, 64'h165969b4797b9,
        64'h1a4964a, 64'h14a649a083, 64'h1a01a60640, 64'h183181686461a,
        64'h1149124264, 64'h1308129249264, 64'h1024426, 64'h1832824426,
        64'h1a49a64b23, 64'h108228b49a4a6, 64'h13b201606461a, 64'h164161a48121b8b1,
        64'h1964936913b63, 64'h18b1810b61914641, 64'h13b6360064, 64'h1648b68,
        64'h17a678a89a, 64'h10730a709a67a, 64'h1a671a7178180, 64'h1a67a71173,
        64'h1126168189867, 64'h1269291679093739, 64'h1780706602, 64'h1732672,
        64'h123ba68a89867, 64'h120727b09767a9a7, 64'h11801781a767a23b, 64'h1b21b17a61671,
        64'h1896867916b63136, 64'h1091b67, 64'h17807063b0b60, 64'h17b6,
        64'h176b, 64'h1308b76, 64'h1019b76, 64'h1819831b76,
        64'h1a126b7, 64'h112a3086b7, 64'h12902a96b7, 64'h16b72a3a83a98,
        64'h1723627, 64'h1708760620, 64'h1276237019, 64'h1162186198876,
        64'h1a76a17137, 64'h1a7617a187108, 64'h103707a0a96a7, 64'h176a7a88a9,
        64'h1684b86, 64'h136b306046, 64'h186b846901, 64'h1946963931b36,
        64'h16846b82a1, 64'h112a30b06b046, 64'h14b846b0292a9, 64'h1a93a32943b36463,
        64'h1823842462, 64'h1042462, 64'h1190234246438, 64'h1194142246,
        64'h18138618466a1, 64'h1a10a06604, 64'h14634386a3039a93, 64'h1a946a4,
        64'h149576b, 64'h1083495b76, 64'h150154076b, 64'h1b76834354315,
        64'h1954a1276b, 64'h16b712a083495, 64'h176b54a42a402, 64'h1348354325a52b76,
        64'h1723762549, 64'h1954086062687, 64'h1362376150540, 64'h1628687218485158,
        64'h1954a16176137, 64'h116a176107870954, 64'h140a4a503a6a737a, 64'h176a7a854a48a,
        64'h16956b9b89, 64'h136b063056095, 64'h10b805b01556b, 64'h16b3635531,
        64'h112a95b9b8b56, 64'h10b306b09656912a, 64'h1b85b56805a52025, 64'h16b36352a3a53,
        64'h1589528562382, 64'h1956960062, 64'h1158180568382628, 64'h1156216,
        64'h113616a386569896, 64'h1a10a06950560, 64'h103856a, 64'h1a56,
        64'h1b5a75b, 64'h1b5ab75830, 64'h15b75ab190, 64'h1a75ab7981831,
        64'h1b12b71751, 64'h108312717572b, 64'h19759279022b7, 64'h175272b592328982,
        64'h125a235375, 64'h1820852875a25, 64'h19015a35373a2, 64'h1982921872a25752,
        64'h1135375, 64'h1087071175, 64'h1903935537, 64'h1987597,
        64'h15845a8ab8, 64'h15045b05abb30, 64'h101984a8aba45, 64'h1ab4a45b34941314,
        64'h12512852b8458, 64'h104b0b345b2b151b, 64'h10250592b5458b85, 64'h19452b3,
        64'h125a352345384, 64'h15a2524420, 64'h13a235a385458019, 64'h15a2524192942,
        64'h1845853351, 64'h1045105, 64'h1845853905035, 64'h1945,
        64'h14b749b9ab, 64'h10834979b79ab, 64'h11ab1b414074b, 64'h13143481a474bab4,
        64'h14b79b492b912, 64'h19749b791b2b1083, 64'h1b74b42240, 64'h1b74b42834324,
        64'h129a279237749, 64'h19a7974a27870207, 64'h137a3a274a1a040a, 64'h11a2874,
        64'h1491417713, 64'h1491417081871, 64'h1403743, 64'h1487,
        64'h19a8ab8, 64'h130939bb9a, 64'h101a0a88ab, 64'h131ab3a,
        64'h112b1b99b8, 64'h130939b1292b9, 64'h102b80b, 64'h132b,
        64'h123828aa89, 64'h19a2092, 64'h123828a0181a8, 64'h11a2,
        64'h1138918, 64'h1091, 64'h1038, 64'h1
    };

    // triangle count from the sentinel position (all nibbles above it are zero)
    function automatic logic [2:0] tri_count(input logic [63:0] ent);
        logic [2:0] n;
        begin
            if (ent[63:60] != 4'd0)
                n = 3'd5;
            else if (ent[51:48] != 4'd0)
                n = 3'd4;
            else if (ent[39:36] != 4'd0)
                n = 3'd3;
            else if (ent[27:24] != 4'd0)
                n = 3'd2;
            else if (ent[15:12] != 4'd0)
                n = 3'd1;
            else
                n = 3'd0;
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/marching_cubes_cell_triangulator.sv
`default_nettype none

// Marching-cubes cell triangulator. A cell transaction is taken whenever cell_valid is high
// and cell_stall low; a cell then passes the stage-1 register (case index and edge
// differences), one multiply stage, a 12-stage radix-4 divider for the edge interpolation
// and one vertex-add stage before the triangle emitter. While tri_stall is low the emitter
// drives one triangle per cycle on the single result port; cells with no triangle give no
// transaction. The pipeline takes a new cell every cycle while the emitter can load, so the
// sustained rate is set by the triangle count of each cell. iso_level and cell_size must be
// written through the cfg port only while the block is idle; the block does not enforce it.
module marching_cubes_cell_triangulator
    import mc_tri_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cell_valid,
    output logic               cell_stall,
    input  wire cell_t         cell_data,
    output logic               tri_valid,
    input  wire logic          tri_stall,
    output tri_t               tri_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    logic signed [SAMPLE_W-1:0] iso_reg;
    logic [SAMPLE_W-1:0]        cell_size_reg;
    logic [UNIT_W-1:0]          unit;

    logic adv;

    // stage 1
    logic                 s1_valid_reg;
    logic [CRD_W-1:0]     s1_base_reg [NUM_AXES];
    logic [7:0]           s1_idx_reg;
    logic [DIFF_W-1:0]    s1_num_reg [NUM_EDGES];
    logic [DIFF_W-1:0]    s1_den_reg [NUM_EDGES];
    logic [7:0]           s1_idx_next;
    logic [DIFF_W-1:0]    s1_num_next [NUM_EDGES];
    logic [DIFF_W-1:0]    s1_den_next [NUM_EDGES];
    logic signed [SAMPLE_W-1:0] cv [NUM_CORNERS];

    // stage 2
    logic                 s2_valid_reg;
    logic [7:0]           s2_idx_reg;
    logic [DVD_W-1:0]     s2_n_reg [NUM_EDGES];
    logic [DIFF_W-1:0]    s2_d_reg [NUM_EDGES];
    logic [POS_W-1:0]     s2_p0_reg [NUM_AXES];
    logic [POS_W-1:0]     s2_p1_reg [NUM_AXES];

    // divider stages
    logic                 dv_valid_reg [DIV_STAGES];
    logic [7:0]           dv_idx_reg [DIV_STAGES];
    logic [DIFF_W-1:0]    dv_rem_reg [DIV_STAGES][NUM_EDGES];
    logic [QUO_W-1:0]     dv_w_reg [DIV_STAGES][NUM_EDGES];
    logic [DIFF_W-1:0]    dv_d_reg [DIV_STAGES][NUM_EDGES];
    logic [POS_W-1:0]     dv_p0_reg [DIV_STAGES][NUM_AXES];
    logic [POS_W-1:0]     dv_p1_reg [DIV_STAGES][NUM_AXES];
    logic [DIFF_W-1:0]    dv_rem_next [DIV_STAGES][NUM_EDGES];
    logic [QUO_W-1:0]     dv_w_next [DIV_STAGES][NUM_EDGES];

    // vertex stage
    logic                 sf_valid_reg;
    logic [63:0]          sf_tri_reg;
    logic [2:0]           sf_n_reg;
    logic [POS_W-1:0]     sf_vert_reg [NUM_EDGES][NUM_AXES];
    logic [POS_W-1:0]     sf_vert_next [NUM_EDGES][NUM_AXES];

    // emitter
    logic                 em_valid_reg;
    logic [63:0]          em_tri_reg;
    logic [2:0]           em_n_reg;
    logic [2:0]           em_t_reg;
    logic [POS_W-1:0]     em_vert_reg [NUM_EDGES][NUM_AXES];
    logic                 em_last;
    logic                 tri_ready;
    logic [POS_W-1:0]     tv [3][NUM_AXES];

    logic                 tri_valid_reg;
    tri_t                 tri_data_reg;
    tri_t                 tri_data_next;

    assign unit       = {cell_size_reg, 8'd0};
    assign cfg_ready  = 1'b1;
    assign tri_ready  = !tri_valid_reg || !tri_stall;
    assign em_last    = (em_t_reg + 3'd1) == em_n_reg;
    assign adv        = !em_valid_reg || (tri_ready && em_last);
    assign cell_stall = !adv;
    assign tri_valid  = tri_valid_reg;
    assign tri_data   = tri_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_reg       <= '0;
            cell_size_reg <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ISO_LEVEL)
                iso_reg <= cfg_data;
            else if (cfg_index == CFG_CELL_SIZE)
                cell_size_reg <= cfg_data;
        end
    end

    // stage 1: case index and per-edge distances
    always_comb
    begin
        logic [DIFF_W:0] a;
        logic [DIFF_W:0] b;
        logic [DIFF_W:0] c;
        cv[0] = cell_data.corner0;
        cv[1] = cell_data.corner1;
        cv[2] = cell_data.corner2;
        cv[3] = cell_data.corner3;
        cv[4] = cell_data.corner4;
        cv[5] = cell_data.corner5;
        cv[6] = cell_data.corner6;
        cv[7] = cell_data.corner7;
        for (int i = 0; i < NUM_CORNERS; i++)
            s1_idx_next[i] = cv[i] < iso_reg;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            a = {{2{cv[EDGE_LO[e]][SAMPLE_W-1]}}, cv[EDGE_LO[e]]};
            b = {{2{cv[EDGE_HI[e]][SAMPLE_W-1]}}, cv[EDGE_HI[e]]};
            c = {{2{iso_reg[SAMPLE_W-1]}}, iso_reg};
            if (s1_idx_next[EDGE_LO[e]])
            begin
                s1_num_next[e] = DIFF_W'(c - a);
                s1_den_next[e] = DIFF_W'(b - a);
            end
            else
            begin
                s1_num_next[e] = DIFF_W'(a - c);
                s1_den_next[e] = DIFF_W'(a - b);
            end
        end
    end

    // divider: two restoring steps per stage
    always_comb
    begin
        logic [DIFF_W-1:0] r;
        logic [QUO_W-1:0]  w;
        logic [DIFF_W:0]   t;
        logic [DIFF_W:0]   df;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                if (s == 0)
                begin
                    r = s2_n_reg[e][DVD_W-2 -: DIFF_W];
                    w = s2_n_reg[e][QUO_W-1:0];
                end
                else
                begin
                    r = dv_rem_reg[s-1][e];
                    w = dv_w_reg[s-1][e];
                end
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    t  = {r, w[QUO_W-1]};
                    df = t - {1'b0, (s == 0) ? s2_d_reg[e] : dv_d_reg[s-1][e]};
                    if (!df[DIFF_W])
                    begin
                        r = df[DIFF_W-1:0];
                        w = {w[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = t[DIFF_W-1:0];
                        w = {w[QUO_W-2:0], 1'b0};
                    end
                end
                dv_rem_next[s][e] = r;
                dv_w_next[s][e]   = w;
            end
        end
    end

    // vertex positions: low corner plus interpolated offset along the edge axis
    always_comb
    begin
        logic [POS_W-1:0] p;
        for (int e = 0; e < NUM_EDGES; e++)
            for (int k = 0; k < NUM_AXES; k++)
            begin
                p = CORNER_OFF[EDGE_LO[e]][k] ? dv_p1_reg[DIV_STAGES-1][k]
                                               : dv_p0_reg[DIV_STAGES-1][k];
                if (EDGE_AXIS[e] == 2'(k))
                    sf_vert_next[e][k] = p + POS_W'(dv_w_reg[DIV_STAGES-1][e]);
                else
                    sf_vert_next[e][k] = p;
            end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sf_valid_reg <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++)
                dv_valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= cell_valid;
            s2_valid_reg    <= s1_valid_reg;
            dv_valid_reg[0] <= s2_valid_reg;
            for (int s = 1; s < DIV_STAGES; s++)
                dv_valid_reg[s] <= dv_valid_reg[s-1];
            sf_valid_reg    <= dv_valid_reg[DIV_STAGES-1];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_base_reg[0] <= cell_data.cell_x;
            s1_base_reg[1] <= cell_data.cell_y;
            s1_base_reg[2] <= cell_data.cell_z;
            s1_idx_reg     <= s1_idx_next;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                s1_num_reg[e] <= s1_num_next[e];
                s1_den_reg[e] <= s1_den_next[e];
            end

            s2_idx_reg <= s1_idx_reg;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                s2_n_reg[e] <= {PROD_W'(cell_size_reg * s1_num_reg[e]), 9'd0}
                               + DVD_W'(s1_den_reg[e]);
                s2_d_reg[e] <= {s1_den_reg[e][DIFF_W-2:0], 1'b0};
            end
            for (int k = 0; k < NUM_AXES; k++)
            begin
                s2_p0_reg[k] <= POS_W'({1'b0, s1_base_reg[k]} * unit);
                s2_p1_reg[k] <= POS_W'(({1'b0, s1_base_reg[k]} + 11'd1) * unit);
            end

            dv_idx_reg[0] <= s2_idx_reg;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                dv_p0_reg[0][k] <= s2_p0_reg[k];
                dv_p1_reg[0][k] <= s2_p1_reg[k];
            end
            for (int e = 0; e < NUM_EDGES; e++)
                dv_d_reg[0][e] <= s2_d_reg[e];
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                dv_idx_reg[s] <= dv_idx_reg[s-1];
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    dv_p0_reg[s][k] <= dv_p0_reg[s-1][k];
                    dv_p1_reg[s][k] <= dv_p1_reg[s-1][k];
                end
                for (int e = 0; e < NUM_EDGES; e++)
                    dv_d_reg[s][e] <= dv_d_reg[s-1][e];
            end
            for (int s = 0; s < DIV_STAGES; s++)
                for (int e = 0; e < NUM_EDGES; e++)
                begin
                    dv_rem_reg[s][e] <= dv_rem_next[s][e];
                    dv_w_reg[s][e]   <= dv_w_next[s][e];
                end

            sf_tri_reg <= TRI_TAB[dv_idx_reg[DIV_STAGES-1]];
            sf_n_reg   <= tri_count(TRI_TAB[dv_idx_reg[DIV_STAGES-1]]);
            for (int e = 0; e < NUM_EDGES; e++)
                for (int k = 0; k < NUM_AXES; k++)
                    sf_vert_reg[e][k] <= sf_vert_next[e][k];

            em_tri_reg <= sf_tri_reg;
            em_n_reg   <= sf_n_reg;
            for (int e = 0; e < NUM_EDGES; e++)
                for (int k = 0; k < NUM_AXES; k++)
                    em_vert_reg[e][k] <= sf_vert_reg[e][k];
        end
    end

    // triangle select: edge nibble for vertex j of triangle t
    always_comb
    begin
        logic [3:0] pos;
        logic [3:0] edg;
        for (int j = 0; j < 3; j++)
        begin
            pos = 4'(4'(em_n_reg) * 4'd3 - 4'd1 - 4'(em_t_reg) * 4'd3 - 4'(j));
            edg = em_tri_reg[pos*4 +: 4];
            for (int k = 0; k < NUM_AXES; k++)
                tv[j][k] = (edg < 4'(NUM_EDGES)) ? em_vert_reg[edg][k] : em_vert_reg[0][k];
        end
        tri_data_next.ax            = tv[0][0];
        tri_data_next.ay            = tv[0][1];
        tri_data_next.az            = tv[0][2];
        tri_data_next.bx            = tv[1][0];
        tri_data_next.by_coord      = tv[1][1];
        tri_data_next.bz            = tv[1][2];
        tri_data_next.cx            = tv[2][0];
        tri_data_next.cy            = tv[2][1];
        tri_data_next.cz            = tv[2][2];
        tri_data_next.last_triangle = em_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg  <= 1'b0;
            em_t_reg      <= '0;
            tri_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                em_valid_reg <= sf_valid_reg && (sf_n_reg != 3'd0);
                em_t_reg     <= '0;
            end
            else if (tri_ready)
                em_t_reg <= em_t_reg + 3'd1;
            if (tri_ready)
                tri_valid_reg <= em_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tri_ready)
            tri_data_reg <= tri_data_next;
    end

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        em_valid_reg |-> (em_t_reg < em_n_reg) && (em_n_reg <= 3'(MAX_TRI)))
        else $error("emitter triangle counter out of range");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> em_valid_reg)
        else $error("cells stalled while emitter idle");

    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (em_valid_reg && tri_ready && !em_last) |=> em_valid_reg && (em_t_reg != 3'd0))
        else $error("emitter lost a cell mid-way");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (tri_valid && tri_stall) |=> tri_valid && $stable(tri_data))
        else $error("stalled triangle transaction changed");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top;
    import mc_tri_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam string EDGE_LISTS [0:255] = '{
        "", "083", "019", "183981",
        "12a", "08312a", "92a029", "2832a8a98",
        "3b2", "0b28b0", "19023b", "1b219b98b",
        "3a1ba3", "0a108a8ba", "3903b9ba9", "98aa8b",
        "478", "430734", "019847", "419471731",
        "12a847", "34730412a", "92a902847", "2a9297273794",
        "8473b2", "b47b24204", "90184723b", "47b94b9b2921",
        "3a13ba784", "1ba14b1047b4", "47890b9bab03", "47b4b99ba",
        "954", "954083", "054150", "854835315",
        "12a954", "30812a495", "52a542402", "2a5325354348",
        "95423b", "0b208b495", "05401523b", "21525828b485",
        "a3ba13954", "4950818a18ba", "54050b5bab03", "54858aa8b",
        "978579", "930953573", "078017157", "153357",
        "978957a12", "a12950530573", "802825857a52", "2a5253357",
        "7957893b2", "95797292027b", "23b018178157", "b21b17715",
        "958857a13a3b", "5705097b010aba0", "ba0b03a50807570", "ba57b5",
        "a65", "0835a6", "9015a6", "1831985a6",
        "165261", "165126308", "965906026", "598582526328",
        "23ba65", "b08b20a65", "01923b5a6", "5a61929b298b",
        "63b653513", "08b0b50515b6", "3b6036065059", "65969bb98",
        "5a6478", "43047365a", "1905a6847", "a65197173794",
        "612651478", "125526304347", "847905065026", "739794329596269",
        "3b2784a65", "5a647242027b", "01947823b5a6", "9219b294b7b45a6",
        "8473b53515b6", "51b5b610b7b404b", "059065036b63847", "65969b4797b9",
        "a4964a", "4a649a083", "a01a60640", "83181686461a",
        "149124264", "308129249264", "024426", "832824426",
        "a49a64b23", "08228b49a4a6", "3b201606461a", "64161a48121b8b1",
        "964936913b63", "8b1810b61914641", "3b6360064", "648b68",
        "7a678a89a", "0730a709a67a", "a671a7178180", "a67a71173",
        "126168189867", "269291679093739", "780706602", "732672",
        "23ba68a89867", "20727b09767a9a7", "1801781a767a23b", "b21b17a61671",
        "896867916b63136", "091b67", "7807063b0b60", "7b6",
        "76b", "308b76", "019b76", "819831b76",
        "a126b7", "12a3086b7", "2902a96b7", "6b72a3a83a98",
        "723627", "708760620", "276237019", "162186198876",
        "a76a17137", "a7617a187108", "03707a0a96a7", "76a7a88a9",
        "684b86", "36b306046", "86b846901", "946963931b36",
        "6846b82a1", "12a30b06b046", "4b846b0292a9", "a93a32943b36463",
        "823842462", "042462", "190234246438", "194142246",
        "8138618466a1", "a10a06604", "4634386a3039a93", "a946a4",
        "49576b", "083495b76", "50154076b", "b76834354315",
        "954a1276b", "6b712a083495", "76b54a42a402", "348354325a52b76",
        "723762549", "954086062687", "362376150540", "628687218485158",
        "954a16176137", "16a176107870954", "40a4a503a6a737a", "76a7a854a48a",
        "6956b9b89", "36b063056095", "0b805b01556b", "6b3635531",
        "12a95b9b8b56", "0b306b09656912a", "b85b56805a52025", "6b36352a3a53",
        "589528562382", "956960062", "158180568382628", "156216",
        "13616a386569896", "a10a06950560", "03856a", "a56",
        "b5a75b", "b5ab75830", "5b75ab190", "a75ab7981831",
        "b12b71751", "08312717572b", "9759279022b7", "75272b592328982",
        "25a235375", "820852875a25", "9015a35373a2", "982921872a25752",
        "135375", "087071175", "903935537", "987597",
        "5845a8ab8", "5045b05abb30", "01984a8aba45", "ab4a45b34941314",
        "2512852b8458", "04b0b345b2b151b", "0250592b5458b85", "9452b3",
        "25a352345384", "5a2524420", "3a235a385458019", "5a2524192942",
        "845853351", "045105", "845853905035", "945",
        "4b749b9ab", "0834979b79ab", "1ab1b414074b", "3143481a474bab4",
        "4b79b492b912", "9749b791b2b1083", "b74b42240", "b74b42834324",
        "29a279237749", "9a7974a27870207", "37a3a274a1a040a", "1a2874",
        "491417713", "491417081871", "403743", "487",
        "9a8ab8", "30939bb9a", "01a0a88ab", "31ab3a",
        "12b1b99b8", "30939b1292b9", "02b80b", "32b",
        "23828aa89", "9a2092", "23828a0181a8", "1a2",
        "138918", "091", "038", ""
    };
    localparam int LO_CORNER [0:11] = '{0, 1, 3, 0, 4, 5, 7, 4, 0, 1, 2, 3};
    localparam int HI_CORNER [0:11] = '{1, 2, 2, 3, 5, 6, 6, 7, 4, 5, 6, 7};
    localparam int EDGE_DIR [0:11] = '{0, 1, 0, 1, 0, 1, 0, 1, 2, 2, 2, 2};
    localparam int OFF_X [0:7] = '{0, 1, 1, 0, 0, 1, 1, 0};
    localparam int OFF_Y [0:7] = '{0, 0, 1, 1, 0, 0, 1, 1};
    localparam int OFF_Z [0:7] = '{0, 0, 0, 0, 1, 1, 1, 1};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cell_valid = 1'b0;
    logic        cell_stall;
    cell_t       cell_data = '0;
    logic        tri_valid;
    logic        tri_stall = 1'b0;
    tri_t        tri_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = '0;

    cell_t       pending_cells [$];
    tri_t        expected_tris [$];
    logic signed [15:0] iso_q;
    logic [15:0] size_q;
    int          mismatches = 0;
    int          cells_sent = 0;
    bit          quiet_stretch = 0;

    always #1 clk = ~clk;

    marching_cubes_cell_triangulator i_dut (.*);

    function automatic int hex_nib(byte c);
        if (c >= "a")
            return c - "a" + 10;
        return c - "0";
    endfunction

    task automatic triangulate(cell_t c);
        logic signed [15:0] v [8];
        logic [33:0] vert [12][3];
        logic [33:0] unit;
        logic [63:0] num, den, frac;
        logic [33:0] pos [3];
        int          idx, lo, hi, ntri;
        string       s;
        tri_t        t;
        logic [33:0] p [9];
        begin
            v = '{c.corner0, c.corner1, c.corner2, c.corner3,
                  c.corner4, c.corner5, c.corner6, c.corner7};
            unit = {18'd0, size_q} << 8;
            idx = 0;
            for (int i = 0; i < 8; i++)
                if (v[i] < iso_q)
                    idx |= 1 << i;
            for (int e = 0; e < 12; e++)
            begin
                lo = LO_CORNER[e];
                hi = HI_CORNER[e];
                for (int k = 0; k < 3; k++)
                    vert[e][k] = '0;
                if (((idx >> lo) & 1) == ((idx >> hi) & 1))
                    continue;
                if (v[lo] < iso_q)
                begin
                    num = 64'(longint'(iso_q) - longint'(v[lo]));
                    den = 64'(longint'(v[hi]) - longint'(v[lo]));
                end
                else
                begin
                    num = 64'(longint'(v[lo]) - longint'(iso_q));
                    den = 64'(longint'(v[lo]) - longint'(v[hi]));
                end
                frac = (2 * 64'(unit) * num + den) / (2 * den);
                pos[0] = 34'((64'(c.cell_x) + OFF_X[lo]) * unit);
                pos[1] = 34'((64'(c.cell_y) + OFF_Y[lo]) * unit);
                pos[2] = 34'((64'(c.cell_z) + OFF_Z[lo]) * unit);
                pos[EDGE_DIR[e]] = 34'(pos[EDGE_DIR[e]] + frac);
                for (int k = 0; k < 3; k++)
                    vert[e][k] = pos[k];
            end
            s = EDGE_LISTS[idx];
            ntri = s.len() / 3;
            for (int n = 0; n < ntri; n++)
            begin
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        p[j * 3 + k] = vert[hex_nib(s[n * 3 + j])][k];
                t.ax = p[0]; t.ay = p[1]; t.az = p[2];
                t.bx = p[3]; t.by_coord = p[4]; t.bz = p[5];
                t.cx = p[6]; t.cy = p[7]; t.cz = p[8];
                t.last_triangle = (n == ntri - 1);
                expected_tris.push_back(t);
            end
        end
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(iso_q);
            3: return 16'(iso_q + $signed(16'($urandom_range(0, 64))) - 16'sd32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cell_t rand_cell();
        cell_t c;
        c.cell_x = 10'($urandom);
        c.cell_y = 10'($urandom);
        c.cell_z = 10'($urandom);
        c.corner0 = rand_sample(); c.corner1 = rand_sample();
        c.corner2 = rand_sample(); c.corner3 = rand_sample();
        c.corner4 = rand_sample(); c.corner5 = rand_sample();
        c.corner6 = rand_sample(); c.corner7 = rand_sample();
        return c;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (cell_valid && !cell_stall)
            cells_sent <= cells_sent + 1;
        if (!cell_valid || !cell_stall)
        begin
            if (pending_cells.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 33))
            begin
                triangulate(pending_cells[0]);
                cell_data  <= pending_cells.pop_front();
                cell_valid <= 1'b1;
            end
            else
                cell_valid <= 1'b0;
        end
        tri_stall <= !quiet_stretch && ($urandom_range(0, 99) < 33);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && tri_valid && !tri_stall)
        begin
            if (expected_tris.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected triangle %p", tri_data);
            end
            else if (tri_data !== expected_tris[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("triangle mismatch\n  exp %p\n  got %p",
                             expected_tris[0], tri_data);
                void'(expected_tris.pop_front());
            end
            else
                void'(expected_tris.pop_front());
        end
    end

    task automatic write_reg(cfg_idx_t r, logic [15:0] val);
        begin
            cfg_index <= r;
            cfg_data  <= val;
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            if (r == CFG_ISO_LEVEL)
                iso_q = val;
            else
                size_q = val;
            @(posedge clk);
        end
    endtask

    task automatic run_phase(int n_items, bit with_directed);
        cell_t c;
        int    target;
        begin
            target = cells_sent;
            if (with_directed)
            begin
                c = '0;
                pending_cells.push_back(c);
                c = '1;
                c.corner0 = 16'h8000; c.corner1 = 16'h7fff; c.corner2 = 16'h8000;
                c.corner3 = 16'h7fff; c.corner4 = 16'h7fff; c.corner5 = 16'h8000;
                c.corner6 = 16'h7fff; c.corner7 = 16'h8000;
                pending_cells.push_back(c);
                for (int i = 0; i < 8; i++)
                begin
                    c = rand_cell();
                    {c.corner0, c.corner1, c.corner2, c.corner3,
                     c.corner4, c.corner5, c.corner6, c.corner7} = {8{16'(iso_q)}};
                    c[16 * (7 - i) +: 16] = 16'h8000;
                    pending_cells.push_back(c);
                end
                c = rand_cell();
                {c.corner0, c.corner1, c.corner2, c.corner3,
                 c.corner4, c.corner5, c.corner6, c.corner7} = {8{16'h8000}};
                pending_cells.push_back(c);
                for (int i = 0; i < 6; i++)
                    pending_cells.push_back(rand_cell());
            end
            for (int i = 0; i < n_items; i++)
                pending_cells.push_back(rand_cell());
            target += pending_cells.size();
            wait (cells_sent == target);
            wait (expected_tris.size() == 0);
            repeat (40) @(posedge clk);
        end
    endtask

    initial
    begin
        iso_q  = 16'sd0;
        size_q = 16'd256;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_phase(30, 1);
        write_reg(CFG_ISO_LEVEL, 16'h8000);
        write_reg(CFG_CELL_SIZE, 16'hffff);
        run_phase(20, 1);
        write_reg(CFG_ISO_LEVEL, 16'h7fff);
        write_reg(CFG_CELL_SIZE, 16'd0);
        run_phase(20, 0);
        write_reg(CFG_ISO_LEVEL, 16'($urandom));
        write_reg(CFG_CELL_SIZE, 16'($urandom));
        quiet_stretch = 1;
        run_phase(32, 0);
        quiet_stretch = 0;
        write_reg(CFG_ISO_LEVEL, 16'hff80);
        write_reg(CFG_CELL_SIZE, 16'd384);
        run_phase(30, 1);
        if (mismatches == 0 && expected_tris.size() == 0)
            $display("PASS marching_cubes_cell_triangulator");
        else
            $display("FAIL marching_cubes_cell_triangulator");
        $finish;
    end

    initial
    begin
        #200000;
        $display("FAIL marching_cubes_cell_triangulator");
        $finish;
    end

endmodule

`default_nettype wire

// File: marching_cubes_cell_triangulator.f
rtl/core/mc_tri_pkg.sv
rtl/core/marching_cubes_cell_triangulator.sv
sim/tb_top.sv
